// ===== src/oile_pkg.sv =====
// Package for the ordered integer list engine.
// Holds the list capacity, the derived widths, the request and status codes,
// and the per-cell control struct. It depends on nothing.
package oile_pkg;

   // List capacity and derived widths
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int POS_W    = (CNT_W > 4) ? CNT_W : 4;

   // Fixed field widths
   localparam int DATA_W   = 32;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 3;
   localparam int REQ_POS_W = 4;
   localparam int RSP_POS_W = 4;
   localparam int RSP_CNT_W = 5;

   // Request codes
   localparam logic [ACTION_W-1:0] ACT_APPEND  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_READOUT = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_DELETE  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_INIT    = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DEAD    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_MISSING = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd4;

   // Cell operations
   localparam int CELL_OP_W = 3;
   localparam logic [CELL_OP_W-1:0] CELL_HOLD  = 3'd0;
   localparam logic [CELL_OP_W-1:0] CELL_LOAD  = 3'd1;
   localparam logic [CELL_OP_W-1:0] CELL_LEFT  = 3'd2;
   localparam logic [CELL_OP_W-1:0] CELL_RIGHT = 3'd3;
   localparam logic [CELL_OP_W-1:0] CELL_HEAD  = 3'd4;

   // Control for one cell
   typedef struct packed {
      logic [CELL_OP_W-1:0] op;
      logic                 capture;  // register the compare result
      logic                 live;     // cell holds an entry of the list
   } cell_ctrl_type;

endpackage

// ===== src/ordered_integer_list_engine_unit.sv =====
// Top level of the ordered integer list engine: request decode, count and
// dead flags, the output register and the chain of list cells.
// Depends on oile_pkg and oile_cell.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  action, position, value
//   rsp_     out        rsp_valid/rsp_stall  status, element, element_position,
//                                            is_empty, last, entry_count
//
// Append, insert, delete, init, spare codes and dead-list refusals are answered at accept.
// Remove goes through S_SEARCH, found or not: the cells register their compare, then the
// chain shifts on a match. Readout sends the entries in order as the chain rotates the list
// through cell 0, or one is_empty result if none. The request side is stalled meanwhile.
// Reset (synchronous) empties the list and clears the dead flag.
// A stalled output register holds its item and stalls the request side.
module ordered_integer_list_engine_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [oile_pkg::ACTION_W-1:0]        req_action,
   input  logic [oile_pkg::REQ_POS_W-1:0]       req_position,
   input  logic signed [oile_pkg::DATA_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [oile_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [oile_pkg::DATA_W-1:0]   rsp_element,
   output logic [oile_pkg::RSP_POS_W-1:0]       rsp_element_position,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_last,
   output logic [oile_pkg::RSP_CNT_W-1:0]       rsp_entry_count
);

   localparam int CAP   = oile_pkg::CAPACITY;
   localparam int CNT_W = oile_pkg::CNT_W;
   localparam int IDX_W = oile_pkg::IDX_W;
   localparam int POS_W = oile_pkg::POS_W;
   localparam int DW    = oile_pkg::DATA_W;

   localparam int STATE_W = 2;
   localparam logic [STATE_W-1:0] S_IDLE   = 2'd0;
   localparam logic [STATE_W-1:0] S_SEARCH = 2'd1;
   localparam logic [STATE_W-1:0] S_READ   = 2'd2;

   logic [STATE_W-1:0] state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               dead_ff, dead_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [oile_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [DW-1:0]                     rsp_element_ff, rsp_element_in;
   logic [oile_pkg::RSP_POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic                              rsp_empty_ff, rsp_empty_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic [oile_pkg::RSP_CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic          out_free, accept;
   logic          do_append, do_insert, do_capture, do_shift, do_rotate;
   logic          full, rd_last;
   logic [POS_W-1:0] pos_wide, count_wide;
   logic [CNT_W-1:0] count_m1;
   logic [DW-1:0] cell_entry [CAP];
   logic [CAP-1:0] cell_hit, hit_upto;
   oile_pkg::cell_ctrl_type cell_ctrl [CAP];

   // Handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign full       = (count_ff == CNT_W'(CAP));
   assign pos_wide   = POS_W'(req_position);
   assign count_wide = POS_W'(count_ff);
   assign count_m1   = count_ff - CNT_W'(1);
   assign rd_last    = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff);

   // First match across the chain
   genvar g;
   generate
      for (g = 0; g < CAP; g++) begin : g_hit
         if (g == 0) begin : g_first
            assign hit_upto[g] = cell_hit[g];
         end else begin : g_rest
            assign hit_upto[g] = hit_upto[g-1] | cell_hit[g];
         end
      end
   endgenerate

   // Request decode and result formation
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      dead_in        = dead_ff;
      rd_idx_in      = rd_idx_ff;
      do_append      = 1'b0;
      do_insert      = 1'b0;
      do_capture     = 1'b0;
      do_shift       = 1'b0;
      do_rotate      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_count_in   = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = oile_pkg::STAT_OK;
               rsp_element_in = '0;
               rsp_pos_in     = '0;
               rsp_empty_in   = 1'b0;
               rsp_last_in    = 1'b1;
               if (dead_ff && (req_action <= oile_pkg::ACT_DELETE)) begin
                  rsp_status_in = oile_pkg::STAT_DEAD;
               end else begin
                  case (req_action)
                     oile_pkg::ACT_APPEND: begin
                        if (full) begin
                           rsp_status_in = oile_pkg::STAT_FULL;
                        end else begin
                           do_append = 1'b1;
                           count_in  = count_ff + CNT_W'(1);
                        end
                     end
                     oile_pkg::ACT_INSERT: begin
                        if (pos_wide >= count_wide) begin
                           rsp_status_in = oile_pkg::STAT_RANGE;
                        end else if (full) begin
                           rsp_status_in = oile_pkg::STAT_FULL;
                        end else begin
                           do_insert = 1'b1;
                           count_in  = count_ff + CNT_W'(1);
                        end
                     end
                     oile_pkg::ACT_REMOVE: begin
                        do_capture   = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = S_SEARCH;
                     end
                     oile_pkg::ACT_READOUT: begin
                        if (count_ff == '0) begin
                           rsp_empty_in = 1'b1;
                        end else begin
                           rsp_valid_in = 1'b0;
                           rd_idx_in    = '0;
                           state_in     = S_READ;
                        end
                     end
                     oile_pkg::ACT_DELETE: begin
                        count_in = '0;
                        dead_in  = 1'b1;
                     end
                     oile_pkg::ACT_INIT: begin
                        count_in = '0;
                        dead_in  = 1'b0;
                     end
                     default: ;
                  endcase
               end
               rsp_count_in = oile_pkg::RSP_CNT_W'(count_in);
            end
         end
         S_SEARCH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_element_in = '0;
               rsp_pos_in     = '0;
               rsp_empty_in   = 1'b0;
               rsp_last_in    = 1'b1;
               if (hit_upto[CAP-1]) begin
                  do_shift      = 1'b1;
                  count_in      = count_m1;
                  rsp_status_in = oile_pkg::STAT_OK;
               end else begin
                  rsp_status_in = oile_pkg::STAT_MISSING;
               end
               rsp_count_in = oile_pkg::RSP_CNT_W'(count_in);
               state_in     = S_IDLE;
            end
         end
         S_READ: begin
            if (out_free) begin
               do_rotate      = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = oile_pkg::STAT_OK;
               rsp_element_in = cell_entry[0];
               rsp_pos_in     = oile_pkg::RSP_POS_W'(rd_idx_ff);
               rsp_empty_in   = 1'b0;
               rsp_last_in    = rd_last;
               rsp_count_in   = oile_pkg::RSP_CNT_W'(count_ff);
               rd_idx_in      = rd_idx_ff + IDX_W'(1);
               if (rd_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dead_ff      <= 1'b0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dead_ff      <= dead_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // Cell chain with per-cell control
   generate
      for (g = 0; g < CAP; g++) begin : g_cell
         logic [DW-1:0] left_value, right_value;

         if (g == 0) begin : g_left_edge
            assign left_value = cell_entry[g];
         end else begin : g_left
            assign left_value = cell_entry[g-1];
         end
         if (g == CAP - 1) begin : g_right_edge
            assign right_value = cell_entry[g];
         end else begin : g_right
            assign right_value = cell_entry[g+1];
         end

         always_comb begin
            cell_ctrl[g].op      = oile_pkg::CELL_HOLD;
            cell_ctrl[g].capture = do_capture;
            cell_ctrl[g].live    = (CNT_W'(g) < count_ff);
            if (do_append && (CNT_W'(g) == count_ff)) begin
               cell_ctrl[g].op = oile_pkg::CELL_LOAD;
            end else if (do_insert && (POS_W'(g) == pos_wide)) begin
               cell_ctrl[g].op = oile_pkg::CELL_LOAD;
            end else if (do_insert && (POS_W'(g) > pos_wide)) begin
               cell_ctrl[g].op = oile_pkg::CELL_LEFT;
            end else if (do_shift && hit_upto[g]) begin
               cell_ctrl[g].op = oile_pkg::CELL_RIGHT;
            end else if (do_rotate && (CNT_W'(g) == count_m1)) begin
               cell_ctrl[g].op = oile_pkg::CELL_HEAD;
            end else if (do_rotate && (CNT_W'(g) < count_m1)) begin
               cell_ctrl[g].op = oile_pkg::CELL_RIGHT;
            end
         end

         oile_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl[g]),
            .load_value  (req_value),
            .left_value  (left_value),
            .right_value (right_value),
            .head_value  (cell_entry[0]),
            .entry       (cell_entry[g]),
            .hit         (cell_hit[g])
         );
      end
   endgenerate

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_element          = rsp_element_ff;
   assign rsp_element_position = rsp_pos_ff;
   assign rsp_is_empty         = rsp_empty_ff;
   assign rsp_last             = rsp_last_ff;
   assign rsp_entry_count      = rsp_count_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAP))
      else $error("entry count above capacity");

   a_dead_empty: assert property (@(posedge clock) disable iff (reset)
      dead_ff |-> (count_ff == '0))
      else $error("dead list holds entries");

   a_read_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (CNT_W'(rd_idx_ff) < count_ff))
      else $error("readout index beyond list");

   a_read_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (count_ff == $past(count_ff)))
      else $error("count changed during readout");

   a_read_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_READ) && out_free && rd_last) |=>
         (rsp_valid_ff && rsp_last_ff && (state_ff == S_IDLE)))
      else $error("readout ended without last item");

endmodule

// ===== src/oile_cell.sv =====
// One cell of the list chain: holds one entry and a registered match flag.
// Loads a new value, takes a neighbor's entry, or takes the head entry.
// Depends on oile_pkg.
module oile_cell (
   input  logic                          clock,
   input  oile_pkg::cell_ctrl_type       ctrl,
   input  logic [oile_pkg::DATA_W-1:0]   load_value,
   input  logic [oile_pkg::DATA_W-1:0]   left_value,
   input  logic [oile_pkg::DATA_W-1:0]   right_value,
   input  logic [oile_pkg::DATA_W-1:0]   head_value,
   output logic [oile_pkg::DATA_W-1:0]   entry,
   output logic                          hit
);

   logic [oile_pkg::DATA_W-1:0] entry_ff, entry_in;
   logic                        hit_ff, hit_in;

   // Entry source select
   always_comb begin
      case (ctrl.op)
         oile_pkg::CELL_HOLD:  entry_in = entry_ff;
         oile_pkg::CELL_LOAD:  entry_in = load_value;
         oile_pkg::CELL_LEFT:  entry_in = left_value;
         oile_pkg::CELL_RIGHT: entry_in = right_value;
         oile_pkg::CELL_HEAD:  entry_in = head_value;
         default:              entry_in = entry_ff;
      endcase
   end

   // Match flag for remove, taken at request time
   always_comb begin
      hit_in = hit_ff;
      if (ctrl.capture) begin
         hit_in = ctrl.live && (entry_ff == load_value);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for ordered_integer_list_engine_unit: directed table, then random traffic.
// Depends on oile_pkg and the unit; a built-in list predictor supplies the expected results.
module testbench;
   import oile_pkg::*;

   // Action codes the unit does not define; it answers them with a plain ok
   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
   localparam int RANDOM_ITEMS = 270;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [STATUS_W-1:0]         status;
      logic signed [DATA_W-1:0]    element;
      logic [RSP_POS_W-1:0]        position;
      logic                        is_empty;
      logic                        last_mark;
      logic [RSP_CNT_W-1:0]        count;
   } list_result_type;

   // Hand-written answer for one item; given = 0 means use the predictor
   typedef struct packed {
      logic                  given;
      logic [STATUS_W-1:0]   status;
      logic                  is_empty;
      logic [RSP_CNT_W-1:0]  count;
   } typed_answer_type;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic [REQ_POS_W-1:0]      position;
      logic signed [DATA_W-1:0]  value;
      logic [4:0]                repeats;
      typed_answer_type          answer;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 27;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [ACTION_W-1:0]           req_action;
   logic [REQ_POS_W-1:0]          req_position;
   logic signed [DATA_W-1:0]      req_value;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [STATUS_W-1:0]           rsp_status;
   logic signed [DATA_W-1:0]      rsp_element;
   logic [RSP_POS_W-1:0]          rsp_element_position;
   logic                          rsp_is_empty;
   logic                          rsp_last;
   logic [RSP_CNT_W-1:0]          rsp_entry_count;

   ordered_integer_list_engine_unit uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_position         (req_position),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_element          (rsp_element),
      .rsp_element_position (rsp_element_position),
      .rsp_is_empty         (rsp_is_empty),
      .rsp_last             (rsp_last),
      .rsp_entry_count      (rsp_entry_count)
   );

   // Predictor state: the list as the unit should hold it
   logic signed [DATA_W-1:0] list_cells [CAPACITY];
   int                       list_count;
   bit                       list_dead;

   list_result_type  expected_results [$];
   list_result_type  step_results [$];
   typed_answer_type typed_answers [$];
   int               mismatch_count;

   // Stimulus shaping: recently stored values so removes mostly hit
   logic signed [DATA_W-1:0] value_pool [16];
   int                       pool_fill;
   int                       burst_left;
   stim_row_type             directed_rows [DIRECTED_ROWS];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("testbench failed");
      $finish;
   end

   function automatic list_result_type make_result(input logic [STATUS_W-1:0] status,
                                                   input logic signed [DATA_W-1:0] element,
                                                   input int position, input logic empty,
                                                   input logic last_mark);
      list_result_type r;
      r.status    = status;
      r.element   = element;
      r.position  = position[RSP_POS_W-1:0];
      r.is_empty  = empty;
      r.last_mark = last_mark;
      r.count     = list_count[RSP_CNT_W-1:0];
      return r;
   endfunction

   // Apply one request to the predicted list and collect its results
   function automatic void predict_list_request(input logic [ACTION_W-1:0] act,
                                                input logic [REQ_POS_W-1:0] pos,
                                                input logic signed [DATA_W-1:0] val);
      int i;
      int hit;
      logic [STATUS_W-1:0] st;
      step_results.delete();
      st = STAT_OK;
      // a dead list refuses everything but init and the spare codes
      if (act <= ACT_DELETE && list_dead) begin
         step_results.push_back(make_result(STAT_DEAD, '0, 0, 1'b0, 1'b1));
         return;
      end
      case (act)
         ACT_APPEND: begin
            if (list_count >= CAPACITY) st = STAT_FULL;
            else begin
               list_cells[IDX_W'(list_count)] = val;
               list_count++;
            end
         end
         ACT_INSERT: begin
            if (int'(pos) >= list_count) st = STAT_RANGE;
            else if (list_count >= CAPACITY) st = STAT_FULL;
            else begin
               for (i = list_count; i > int'(pos); i--)
                  list_cells[IDX_W'(i)] = list_cells[IDX_W'(i-1)];
               list_cells[IDX_W'(pos)] = val;
               list_count++;
            end
         end
         ACT_REMOVE: begin
            st = STAT_MISSING;
            hit = -1;
            for (i = 0; i < list_count; i++)
               if (hit < 0 && list_cells[IDX_W'(i)] == val) hit = i;
            if (hit >= 0) begin
               for (i = hit; i + 1 < list_count; i++)
                  list_cells[IDX_W'(i)] = list_cells[IDX_W'(i+1)];
               list_count--;
               st = STAT_OK;
            end
         end
         ACT_READOUT: begin
            if (list_count == 0)
               step_results.push_back(make_result(STAT_OK, '0, 0, 1'b1, 1'b1));
            for (i = 0; i < list_count; i++)
               step_results.push_back(make_result(STAT_OK, list_cells[IDX_W'(i)], i, 1'b0,
                                                  i + 1 == list_count));
            return;
         end
         ACT_DELETE: begin
            list_count = 0;
            list_dead  = 1'b1;
         end
         ACT_INIT: begin
            list_count = 0;
            list_dead  = 1'b0;
         end
         default: ;
      endcase
      step_results.push_back(make_result(st, '0, 0, 1'b0, 1'b1));
   endfunction

   // Check accepted results first, then queue expectations for an accepted item
   always @(posedge clock) begin : check_and_predict
      list_result_type  got;
      list_result_type  want;
      typed_answer_type answer;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_element, rsp_element_position, rsp_is_empty, rsp_last,
                    rsp_entry_count};
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result st=%0d el=%0d pos=%0d emp=%0b last=%0b cnt=%0d",
                           $realtime, got.status, got.element, got.position, got.is_empty,
                           got.last_mark, got.count);
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status || got.element !== want.element ||
                   got.position !== want.position || got.is_empty !== want.is_empty ||
                   got.last_mark !== want.last_mark || got.count !== want.count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: mismatch exp st=%0d el=%0d pos=%0d emp=%0b last=%0b cnt=%0d",
                               " / got st=%0d el=%0d pos=%0d emp=%0b last=%0b cnt=%0d"},
                              $realtime, want.status, want.element, want.position,
                              want.is_empty, want.last_mark, want.count, got.status,
                              got.element, got.position, got.is_empty, got.last_mark,
                              got.count);
               end
            end
         end
         if (req_valid && !req_stall) begin
            answer = typed_answers.pop_front();
            predict_list_request(req_action, req_position, req_value);
            if (answer.given)
               expected_results.push_back('{answer.status, '0, '0, answer.is_empty, 1'b1,
                                            answer.count});
            else
               foreach (step_results[i]) expected_results.push_back(step_results[i]);
         end
      end
   end

   // Receiver stalls: mostly short, a few long, and long stall-free stretches
   initial begin : stall_driver
      int pick;
      rsp_stall <= 1'b0;
      forever begin
         pick = $urandom_range(0, 15);
         if (pick < 2) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(60, 150)) @(posedge clock);
         end else if (pick < 9) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else if (pick < 14) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   // Sender idle gap: bursts with none, otherwise mostly short
   function automatic int pick_gap();
      int pick;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      int pick;
      int near_zero;
      pick = $urandom_range(0, 9);
      near_zero = $urandom_range(0, 16);
      if (pick < 5) return $urandom;
      if (pick < 8) return near_zero - 8;
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         default: return '0;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_remove_value();
      int held;
      held = (pool_fill < 16) ? pool_fill : 16;
      if (held > 0 && $urandom_range(0, 3) != 0)
         return value_pool[4'($urandom_range(0, held - 1))];
      return pick_value();
   endfunction

   function automatic logic [REQ_POS_W-1:0] pick_position();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return REQ_POS_W'($urandom_range(0, 3));
      if (pick < 8) return REQ_POS_W'($urandom_range(0, 10));
      return REQ_POS_W'($urandom_range(0, 15));
   endfunction

   function automatic void remember_value(input logic signed [DATA_W-1:0] val);
      value_pool[4'(pool_fill % 16)] = val;
      pool_fill++;
   endfunction

   // Present one item after an optional idle gap and hold it until accepted
   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [REQ_POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] val,
                            input typed_answer_type answer);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_answers.push_back(answer);
      req_valid    <= 1'b1;
      req_action   <= act;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (typed_answers.size() != 0 || expected_results.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int row;
      int k;
      int counted;
      int pick;
      bit grow;
      bit paused;
      logic [ACTION_W-1:0] act;
      logic signed [DATA_W-1:0] val;
      typed_answer_type predicted;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_action   <= ACT_APPEND;
      req_position <= '0;
      req_value    <= '0;
      list_count     = 0;
      list_dead      = 1'b0;
      mismatch_count = 0;
      pool_fill      = 0;
      burst_left     = 0;
      predicted      = '0;

      // action, position, value, repeats, {typed, status, is_empty, count}
      directed_rows[0]  = '{ACT_READOUT, 4'd0, 32'd0, 5'd1, '{1'b1, STAT_OK, 1'b1, 5'd0}};
      directed_rows[1]  = '{ACT_INSERT, 4'd0, 32'd5, 5'd1, '{1'b1, STAT_RANGE, 1'b0, 5'd0}};
      directed_rows[2]  = '{ACT_REMOVE, 4'd0, 32'd7, 5'd1, '{1'b1, STAT_MISSING, 1'b0, 5'd0}};
      directed_rows[3]  = '{ACT_APPEND, 4'd0, 32'h7FFF_FFFF, 5'd1,
                            '{1'b1, STAT_OK, 1'b0, 5'd1}};
      directed_rows[4]  = '{ACT_APPEND, 4'd0, 32'h8000_0000, 5'd1,
                            '{1'b1, STAT_OK, 1'b0, 5'd2}};
      // insert at the head, then in the middle, then past the end
      directed_rows[5]  = '{ACT_INSERT, 4'd0, 32'hFFFF_FFFF, 5'd1,
                            '{1'b1, STAT_OK, 1'b0, 5'd3}};
      directed_rows[6]  = '{ACT_INSERT, 4'd2, 32'd0, 5'd1, '{1'b1, STAT_OK, 1'b0, 5'd4}};
      directed_rows[7]  = '{ACT_INSERT, 4'd15, 32'd1, 5'd1, '{1'b1, STAT_RANGE, 1'b0, 5'd4}};
      directed_rows[8]  = '{ACT_READOUT, 4'd0, 32'd0, 5'd1, '0};
      directed_rows[9]  = '{ACT_REMOVE, 4'd0, 32'h8000_0000, 5'd1,
                            '{1'b1, STAT_OK, 1'b0, 5'd3}};
      directed_rows[10] = '{ACT_REMOVE, 4'd0, 32'd12345, 5'd1,
                            '{1'b1, STAT_MISSING, 1'b0, 5'd3}};
      directed_rows[11] = '{ACT_SPARE_HI, 4'd9, 32'd3, 5'd1, '{1'b1, STAT_OK, 1'b0, 5'd3}};
      // dead list: every request but init and the spare codes is refused
      directed_rows[12] = '{ACT_DELETE, 4'd0, 32'd0, 5'd1, '{1'b1, STAT_OK, 1'b0, 5'd0}};
      directed_rows[13] = '{ACT_APPEND, 4'd0, 32'd1, 5'd1, '{1'b1, STAT_DEAD, 1'b0, 5'd0}};
      directed_rows[14] = '{ACT_INSERT, 4'd0, 32'd2, 5'd1, '{1'b1, STAT_DEAD, 1'b0, 5'd0}};
      directed_rows[15] = '{ACT_REMOVE, 4'd0, 32'd1, 5'd1, '{1'b1, STAT_DEAD, 1'b0, 5'd0}};
      directed_rows[16] = '{ACT_READOUT, 4'd0, 32'd0, 5'd1, '{1'b1, STAT_DEAD, 1'b0, 5'd0}};
      directed_rows[17] = '{ACT_DELETE, 4'd0, 32'd0, 5'd1, '{1'b1, STAT_DEAD, 1'b0, 5'd0}};
      directed_rows[18] = '{ACT_SPARE_LO, 4'd0, 32'd0, 5'd1, '{1'b1, STAT_OK, 1'b0, 5'd0}};
      directed_rows[19] = '{ACT_INIT, 4'd0, 32'd0, 5'd1, '{1'b1, STAT_OK, 1'b0, 5'd0}};
      // fill to capacity, then hit the full status both ways
      directed_rows[20] = '{ACT_APPEND, 4'd0, -32'sd5, 5'd16, '0};
      directed_rows[21] = '{ACT_APPEND, 4'd0, 32'd3, 5'd1, '{1'b1, STAT_FULL, 1'b0, 5'd16}};
      directed_rows[22] = '{ACT_INSERT, 4'd3, 32'd9, 5'd1, '{1'b1, STAT_FULL, 1'b0, 5'd16}};
      directed_rows[23] = '{ACT_READOUT, 4'd0, 32'd0, 5'd1, '0};
      directed_rows[24] = '{ACT_REMOVE, 4'd0, 32'd10, 5'd1, '{1'b1, STAT_OK, 1'b0, 5'd15}};
      directed_rows[25] = '{ACT_INSERT, 4'd14, 32'h5A5A_5A5A, 5'd1,
                            '{1'b1, STAT_OK, 1'b0, 5'd16}};
      directed_rows[26] = '{ACT_INIT, 4'd0, 32'd0, 5'd1, '{1'b1, STAT_OK, 1'b0, 5'd0}};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      for (row = 0; row < DIRECTED_ROWS; row++)
         for (k = 0; k < directed_rows[5'(row)].repeats; k++)
            send_item(directed_rows[5'(row)].action, directed_rows[5'(row)].position,
                      directed_rows[5'(row)].value + k, directed_rows[5'(row)].answer);

      // Random traffic, alternating between growing and shrinking the list
      counted = 0;
      paused  = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         if (!paused && counted >= RANDOM_ITEMS / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end
         grow = ((counted / 40) % 2) == 0;
         pick = $urandom_range(0, 99);
         if (pick < (grow ? 38 : 14)) begin
            val = pick_value();
            remember_value(val);
            send_item(ACT_APPEND, pick_position(), val, predicted);
            counted++;
         end else if (pick < (grow ? 66 : 26)) begin
            val = pick_value();
            remember_value(val);
            send_item(ACT_INSERT, pick_position(), val, predicted);
            counted++;
         end else if (pick < (grow ? 80 : 70)) begin
            send_item(ACT_REMOVE, pick_position(), pick_remove_value(), predicted);
            counted++;
         end else if (pick < (grow ? 92 : 88)) begin
            send_item(ACT_READOUT, pick_position(), pick_value(), predicted);
            counted++;
         end else if (pick < (grow ? 95 : 92)) begin
            act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
            send_item(act, pick_position(), pick_value(), predicted);
         end else if (pick < (grow ? 97 : 95)) begin
            // delete, one to three requests on the dead list, then revive
            send_item(ACT_DELETE, pick_position(), pick_value(), predicted);
            counted++;
            repeat ($urandom_range(1, 3)) begin
               act = ACTION_W'($urandom_range(0, 5));
               if (act == ACT_INIT) act = ACT_SPARE_HI;
               send_item(act, pick_position(), pick_remove_value(), predicted);
            end
            pool_fill = 0;
            send_item(ACT_INIT, pick_position(), pick_value(), predicted);
            counted++;
         end else begin
            pool_fill = 0;
            send_item(ACT_INIT, pick_position(), pick_value(), predicted);
            counted++;
         end
      end

      // Drain, then give stray results time to show up
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/oile_pkg.sv
src/oile_cell.sv
src/ordered_integer_list_engine_unit.sv
bench/testbench.sv
